// File: design/unary_rank_decoder_macros.svh
// Assertion macros used by the top-level decoder module.
// Each check is sampled on the rising clock edge and is off while reset is low.
`ifndef UNARY_RANK_DECODER_MACROS_SVH
`define UNARY_RANK_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define URD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define URD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define URD_ASSERT(lbl, clk, rst_n, prop, msg)
`define URD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/urd_pkg.sv
package urd_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int ALPHABET_DEF  = 128;

    localparam int SYM_W    = 7;
    localparam int CNT_W    = 16;
    localparam int BC_W     = 6;
    localparam int TABLE_SZ = 128;
    localparam int PADDR_W  = 3;

    localparam logic [CNT_W-1:0] MAX_SYMBOLS_RST = 16'hFFFF;

    // Register index, taken from paddr[2].
    localparam logic REG_MAX_SYMBOLS = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LIMIT    = 2'd1,
        ST_RUN_LONG = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        logic busy;
        logic res_want;
    } t_dp_stat;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_result;

    localparam logic [SYM_W-1:0] RANK_TABLE [TABLE_SZ] = '{
        7'd23, 7'd113, 7'd96, 7'd73, 7'd1, 7'd82, 7'd54, 7'd93, 7'd37, 7'd116, 7'd88,
        7'd39, 7'd6, 7'd55, 7'd46, 7'd7, 7'd19, 7'd49, 7'd66, 7'd64, 7'd104, 7'd45,
        7'd21, 7'd120, 7'd20, 7'd61, 7'd76, 7'd106, 7'd102, 7'd81, 7'd34, 7'd62,
        7'd14, 7'd99, 7'd22, 7'd84, 7'd71, 7'd77, 7'd58, 7'd17, 7'd124, 7'd126,
        7'd27, 7'd117, 7'd41, 7'd97, 7'd12, 7'd4, 7'd32, 7'd38, 7'd13, 7'd25,
        7'd83, 7'd101, 7'd9, 7'd28, 7'd85, 7'd24, 7'd95, 7'd57, 7'd18, 7'd3,
        7'd92, 7'd48, 7'd50, 7'd86, 7'd79, 7'd91, 7'd103, 7'd108, 7'd123, 7'd80,
        7'd125, 7'd5, 7'd90, 7'd70, 7'd94, 7'd89, 7'd87, 7'd44, 7'd2, 7'd33,
        7'd69, 7'd26, 7'd127, 7'd111, 7'd75, 7'd118, 7'd8, 7'd36, 7'd121, 7'd105,
        7'd107, 7'd78, 7'd15, 7'd11, 7'd74, 7'd10, 7'd43, 7'd51, 7'd122, 7'd100,
        7'd72, 7'd63, 7'd98, 7'd68, 7'd119, 7'd16, 7'd65, 7'd60, 7'd52, 7'd42,
        7'd53, 7'd35, 7'd0, 7'd115, 7'd67, 7'd59, 7'd30, 7'd47, 7'd114, 7'd29,
        7'd40, 7'd112, 7'd31, 7'd109, 7'd56, 7'd110
    };

    function automatic logic [SYM_W-1:0] rank_lookup(input logic [SYM_W-1:0] rank);
        return RANK_TABLE[rank];
    endfunction

endpackage

// File: design/urd_seq.sv
module urd_seq
    import urd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output t_ctrl    o_ctrl,
    output logic     o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctrl      = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_stat.busy) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = S_IDLE;
                end else if (!i_stat.res_want || i_out_free) begin
                    // A bit that yields a result waits for the output register.
                    o_ctrl.step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: design/urd_datapath.sv
module urd_datapath
    import urd_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic [WORD_BITS-1:0] i_code_word,
    input  logic [BC_W-1:0]      i_bit_count,
    input  logic                 i_final_word,
    input  logic [CNT_W-1:0]     i_max_symbols,
    output t_dp_stat             o_stat,
    output t_result              o_res
);

    localparam int LEFT_W = $clog2(WORD_BITS + 1);
    localparam int RUN_W  = $clog2(ALPHABET);
    localparam int CMP_W  = 10;

    logic [WORD_BITS-1:0] r_word;
    logic [LEFT_W-1:0]    r_left;
    logic                 r_final;
    logic [RUN_W-1:0]     r_ones_run;
    logic [CNT_W-1:0]     r_total;
    logic                 r_err;

    logic [LEFT_W-1:0]    cnt_sat;
    logic                 cur_bit;
    logic                 run_full;
    logic                 at_limit;
    logic                 more_after;
    logic [7:0]           run_ext;

    always_comb begin
        if (CMP_W'(i_bit_count) > CMP_W'(WORD_BITS)) begin
            cnt_sat = LEFT_W'(WORD_BITS);
        end else begin
            cnt_sat = LEFT_W'(i_bit_count);
        end
    end

    assign cur_bit  = r_word[WORD_BITS-1];
    assign run_full = (r_ones_run >= RUN_W'(ALPHABET - 1));
    assign at_limit = (r_total >= i_max_symbols);
    assign run_ext  = 8'(r_ones_run);

    // Invalid low bits are loaded and shifted in as ones, so a zero below the
    // current bit means another symbol follows; an all-ones tail only adds a
    // result when it is long enough to overflow the run.
    assign more_after = !(&r_word[WORD_BITS-2:0]) ||
                        ((CMP_W'(r_left) - CMP_W'(1)) >= CMP_W'(ALPHABET));

    assign o_stat.busy     = (r_left != '0) && !r_err;
    assign o_stat.res_want = !cur_bit || run_full;

    always_comb begin
        o_res.symbol = '0;
        o_res.count  = r_total;
        o_res.last   = 1'b1;
        if (cur_bit) begin
            o_res.status = ST_RUN_LONG;
        end else if (at_limit) begin
            o_res.status = ST_LIMIT;
        end else begin
            o_res.status = ST_OK;
            o_res.symbol = rank_lookup(run_ext[SYM_W-1:0]);
            o_res.count  = r_total + 1'b1;
            o_res.last   = !more_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_word  <= i_code_word | ({WORD_BITS{1'b1}} >> cnt_sat);
            r_final <= i_final_word;
        end else if (i_ctrl.step) begin
            r_word <= {r_word[WORD_BITS-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_ones_run <= '0;
            r_total    <= '0;
            r_err      <= 1'b0;
        end else if (i_ctrl.load) begin
            r_left <= cnt_sat;
        end else if (i_ctrl.step) begin
            r_left <= r_left - 1'b1;
            if (cur_bit) begin
                if (run_full) begin
                    r_err <= 1'b1;
                end else begin
                    r_ones_run <= r_ones_run + 1'b1;
                end
            end else if (at_limit) begin
                r_err <= 1'b1;
            end else begin
                r_total    <= r_total + 1'b1;
                r_ones_run <= '0;
            end
        end else if (i_ctrl.finish) begin
            r_left <= '0;
            if (r_final) begin
                r_ones_run <= '0;
                r_total    <= '0;
                r_err      <= 1'b0;
            end
        end
    end

endmodule

// File: design/unary_rank_decoder.sv
// Unary rank decoder.
// Input channel: i_in_valid / o_in_stall carry one packed code word per transfer,
// with i_bit_count valid bits read from the top bit down and i_final_word marking
// the last word of a message. Output channel: o_out_valid / i_out_stall carry one
// decoded symbol per transfer, with status, running symbol count and a flag on
// the last result caused by the input word.
// A word is worked through by one bit unit, one bit per cycle while it does not
// pause for the output; the input stays stalled until the word is done. A symbol
// reaches the output register in the cycle after its bit is examined.
// When the receiver stalls with a result waiting, the bit unit pauses on the next
// bit that yields a result; bits that only extend a run of ones keep going.
// Reset clears the run length, the symbol count and the error flag, empties the
// output register and sets max_symbols to 65535. max_symbols lies at byte
// address 0 of the APB port; the user must write it only while the block is
// idle, as the block has no check for it.
module unary_rank_decoder
    import urd_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WORD_BITS-1:0] i_code_word,
    input  logic [BC_W-1:0]      i_bit_count,
    input  logic                 i_final_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SYM_W-1:0]     o_symbol,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_symbols_so_far,
    output logic                 o_last_of_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

`include "unary_rank_decoder_macros.svh"

    t_ctrl            ctrl;
    t_dp_stat         dp_stat;
    t_result          res;
    logic             out_free;
    logic             load_out;
    logic [CNT_W-1:0] r_max_symbols;
    logic             r_out_valid;
    t_result          r_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_symbols <= MAX_SYMBOLS_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_SYMBOLS) begin
            r_max_symbols <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_SYMBOLS) begin
            prdata = {{(32 - CNT_W){1'b0}}, r_max_symbols};
        end
    end

    urd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_ctrl     (ctrl),
        .o_in_stall (o_in_stall)
    );

    urd_datapath #(
        .WORD_BITS (WORD_BITS),
        .ALPHABET  (ALPHABET)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_code_word   (i_code_word),
        .i_bit_count   (i_bit_count),
        .i_final_word  (i_final_word),
        .i_max_symbols (r_max_symbols),
        .o_stat        (dp_stat),
        .o_res         (res)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = ctrl.step && dp_stat.res_want;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_symbol         = r_out.symbol;
    assign o_status         = r_out.status;
    assign o_symbols_so_far = r_out.count;
    assign o_last_of_word   = r_out.last;

    `URD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall, !load_out,
        "result loaded over a stalled result")
    `URD_ASSERT_IMP(a_idle_no_result, i_clk, i_rst_n, !o_in_stall, !load_out,
        "result produced while idle")
    `URD_ASSERT_IMP(a_error_last, i_clk, i_rst_n,
        o_out_valid && o_status != ST_OK, o_symbol == '0 && o_last_of_word,
        "error result is not a zero symbol closing the word")
    `URD_ASSERT_IMP(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall, ##1 o_in_stall,
        "input not stalled after a word transfer")

endmodule
